@@ src/tsss_pkg.sv @@
`default_nettype none

package tsss_pkg;

   // field and time widths
   localparam int TIME_W = 16;
   localparam int CFG_W  = 16;
   localparam int CMP_W  = (TIME_W > CFG_W) ? TIME_W : CFG_W;
   localparam int SUM_W  = CMP_W + 1;
   localparam int CNT_W  = $clog2(TIME_W + 1);
   localparam int IDX_W  = 3;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // register indexes
   localparam logic [IDX_W-1:0] REG_FIRST_PERIOD  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SECOND_PERIOD = 3'd1;
   localparam logic [IDX_W-1:0] REG_THIRD_PERIOD  = 3'd2;
   localparam logic [IDX_W-1:0] REG_FOURTH_PERIOD = 3'd3;
   localparam logic [IDX_W-1:0] REG_PULSE_WIDTH   = 3'd4;
   localparam logic [IDX_W-1:0] REG_PHASE_DUR     = 3'd5;
   localparam logic [IDX_W-1:0] REG_COOL_DUR      = 3'd6;
   localparam logic [IDX_W-1:0] REG_TICK_INC      = 3'd7;

   // channel status codes
   localparam logic [1:0] STAT_OFF  = 2'd0;
   localparam logic [1:0] STAT_ON   = 2'd1;
   localparam logic [1:0] STAT_SOFT = 2'd2;
   localparam logic [1:0] STAT_COOL = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE      = 3'd0,
      SEQ_PHASE1    = 3'd1,
      SEQ_PHASE2    = 3'd2,
      SEQ_PHASE3    = 3'd3,
      SEQ_PHASE4    = 3'd4,
      SEQ_RELAY_ON  = 3'd5,
      SEQ_RELAY_OFF = 3'd6,
      SEQ_COOLING   = 3'd7
   } seq_state_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_START,
      CTRL_DIVIDE,
      CTRL_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic transition;
      logic div_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic in_phase;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ src/tsss_remainder.sv @@
`default_nettype none

// restoring remainder, one dividend bit per cycle
module tsss_remainder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tsss_pkg::TIME_W-1:0]    dividend,
   input  wire logic [tsss_pkg::CFG_W-1:0]     divisor,
   output logic                                done,
   output logic [tsss_pkg::CFG_W-1:0]          remainder
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [tsss_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [tsss_pkg::TIME_W-1:0]      dvd_ff, dvd_in;
   logic [tsss_pkg::CFG_W-1:0]       rem_ff, rem_in;
   logic [tsss_pkg::CFG_W:0]         shifted;
   logic [tsss_pkg::CFG_W:0]         diff;

   assign shifted = {rem_ff, dvd_ff[tsss_pkg::TIME_W-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = tsss_pkg::CNT_W'(tsss_pkg::TIME_W);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[tsss_pkg::TIME_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[tsss_pkg::CFG_W-1:0];
         end else begin
            rem_in = shifted[tsss_pkg::CFG_W-1:0];
         end
         cnt_in = cnt_ff - tsss_pkg::CNT_W'(1);
         if (cnt_ff == tsss_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ src/tsss_datapath.sv @@
`default_nettype none

module tsss_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tsss_pkg::cmd_type                 cmd,
   output tsss_pkg::status_type                   status,
   input  wire logic                              req_wanted_on,
   input  wire logic                              csr_valid,
   input  wire logic [tsss_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [tsss_pkg::CFG_W-1:0]        csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_triac_drive,
   output logic                                   rsp_relay_drive,
   output logic [1:0]                             rsp_channel_status,
   output logic                                   rsp_output_is_on
);

   // configuration registers
   logic [tsss_pkg::CFG_W-1:0] period1_ff, period2_ff, period3_ff, period4_ff;
   logic [tsss_pkg::CFG_W-1:0] pulse_width_ff, phase_dur_ff, cool_dur_ff, tick_inc_ff;

   // sequencer state
   tsss_pkg::seq_state_type       seq_ff, seq_in;
   logic [tsss_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic                          real_on_ff, real_on_in;
   logic                          triac_ff, triac_in;
   logic                          relay_ff, relay_in;
   logic [1:0]                    stat_ff, stat_in;
   logic                          out_on_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          in_phase;
   logic [tsss_pkg::CFG_W-1:0]    period;
   logic [tsss_pkg::CFG_W-1:0]    div_rem;
   logic                          div_done;
   logic [tsss_pkg::CMP_W-1:0]    rem_sel;
   logic [tsss_pkg::SUM_W-1:0]    time_sum;
   logic                          phase_over;
   logic                          cool_over;

   always_ff @(posedge clock) begin
      if (reset) begin
         period1_ff     <= tsss_pkg::CFG_W'(100);
         period2_ff     <= tsss_pkg::CFG_W'(80);
         period3_ff     <= tsss_pkg::CFG_W'(60);
         period4_ff     <= tsss_pkg::CFG_W'(40);
         pulse_width_ff <= tsss_pkg::CFG_W'(20);
         phase_dur_ff   <= tsss_pkg::CFG_W'(1000);
         cool_dur_ff    <= tsss_pkg::CFG_W'(1000);
         tick_inc_ff    <= tsss_pkg::CFG_W'(10);
      end else if (csr_valid) begin
         case (csr_index)
            tsss_pkg::REG_FIRST_PERIOD:  period1_ff     <= csr_data;
            tsss_pkg::REG_SECOND_PERIOD: period2_ff     <= csr_data;
            tsss_pkg::REG_THIRD_PERIOD:  period3_ff     <= csr_data;
            tsss_pkg::REG_FOURTH_PERIOD: period4_ff     <= csr_data;
            tsss_pkg::REG_PULSE_WIDTH:   pulse_width_ff <= csr_data;
            tsss_pkg::REG_PHASE_DUR:     phase_dur_ff   <= csr_data;
            tsss_pkg::REG_COOL_DUR:      cool_dur_ff    <= csr_data;
            tsss_pkg::REG_TICK_INC:      tick_inc_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_phase = 1'b0;
      period   = period1_ff;
      case (seq_ff)
         tsss_pkg::SEQ_PHASE1: begin
            in_phase = 1'b1;
            period   = period1_ff;
         end
         tsss_pkg::SEQ_PHASE2: begin
            in_phase = 1'b1;
            period   = period2_ff;
         end
         tsss_pkg::SEQ_PHASE3: begin
            in_phase = 1'b1;
            period   = period3_ff;
         end
         tsss_pkg::SEQ_PHASE4: begin
            in_phase = 1'b1;
            period   = period4_ff;
         end
         default: ;
      endcase
   end

   tsss_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (elapsed_ff),
      .divisor   (period),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign phase_over = tsss_pkg::CMP_W'(elapsed_ff) >= tsss_pkg::CMP_W'(phase_dur_ff);
   assign cool_over  = tsss_pkg::CMP_W'(elapsed_ff) >= tsss_pkg::CMP_W'(cool_dur_ff);

   // zero period passes the time straight through
   assign rem_sel  = (period == '0) ? tsss_pkg::CMP_W'(elapsed_ff)
                                    : tsss_pkg::CMP_W'(div_rem);
   assign time_sum = tsss_pkg::SUM_W'(elapsed_ff) + tsss_pkg::SUM_W'(tick_inc_ff);

   always_comb begin
      seq_in       = seq_ff;
      elapsed_in   = elapsed_ff;
      real_on_in   = real_on_ff;
      triac_in     = triac_ff;
      relay_in     = relay_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (cmd.transition) begin
         case (seq_ff)
            tsss_pkg::SEQ_IDLE: begin
               if (req_wanted_on != real_on_ff) begin
                  if (req_wanted_on) begin
                     seq_in     = tsss_pkg::SEQ_PHASE1;
                     elapsed_in = '0;
                  end else begin
                     seq_in = tsss_pkg::SEQ_RELAY_OFF;
                  end
               end
            end
            tsss_pkg::SEQ_PHASE1, tsss_pkg::SEQ_PHASE2,
            tsss_pkg::SEQ_PHASE3, tsss_pkg::SEQ_PHASE4: begin
               if (phase_over) begin
                  elapsed_in = '0;
                  case (seq_ff)
                     tsss_pkg::SEQ_PHASE1: seq_in = tsss_pkg::SEQ_PHASE2;
                     tsss_pkg::SEQ_PHASE2: seq_in = tsss_pkg::SEQ_PHASE3;
                     tsss_pkg::SEQ_PHASE3: seq_in = tsss_pkg::SEQ_PHASE4;
                     default:              seq_in = tsss_pkg::SEQ_RELAY_ON;
                  endcase
               end
               if (!req_wanted_on && !triac_ff) begin
                  seq_in     = tsss_pkg::SEQ_RELAY_OFF;
                  elapsed_in = '0;
               end
            end
            tsss_pkg::SEQ_RELAY_ON, tsss_pkg::SEQ_RELAY_OFF: begin
               seq_in     = tsss_pkg::SEQ_COOLING;
               real_on_in = req_wanted_on;
            end
            default: begin
               if (cool_over) begin
                  seq_in     = tsss_pkg::SEQ_IDLE;
                  elapsed_in = '0;
               end else if (!req_wanted_on && real_on_ff) begin
                  seq_in = tsss_pkg::SEQ_RELAY_OFF;
               end
            end
         endcase
      end

      if (cmd.finish) begin
         case (seq_ff)
            tsss_pkg::SEQ_IDLE: begin
               triac_in = 1'b0;
               relay_in = real_on_ff;
               stat_in  = real_on_ff ? tsss_pkg::STAT_ON : tsss_pkg::STAT_OFF;
            end
            tsss_pkg::SEQ_PHASE1, tsss_pkg::SEQ_PHASE2,
            tsss_pkg::SEQ_PHASE3, tsss_pkg::SEQ_PHASE4: begin
               triac_in = rem_sel < tsss_pkg::CMP_W'(pulse_width_ff);
               relay_in = 1'b0;
               stat_in  = tsss_pkg::STAT_SOFT;
            end
            tsss_pkg::SEQ_RELAY_ON: begin
               triac_in = 1'b0;
               relay_in = 1'b1;
               stat_in  = tsss_pkg::STAT_ON;
            end
            tsss_pkg::SEQ_RELAY_OFF: begin
               triac_in = 1'b0;
               relay_in = 1'b0;
               stat_in  = tsss_pkg::STAT_COOL;
            end
            default: begin
               stat_in = real_on_ff ? tsss_pkg::STAT_ON : tsss_pkg::STAT_COOL;
            end
         endcase
         if (time_sum > tsss_pkg::SUM_W'(tsss_pkg::TIME_MAX)) begin
            elapsed_in = tsss_pkg::TIME_MAX;
         end else begin
            elapsed_in = time_sum[tsss_pkg::TIME_W-1:0];
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= tsss_pkg::SEQ_IDLE;
         elapsed_ff   <= '0;
         real_on_ff   <= 1'b0;
         triac_ff     <= 1'b0;
         relay_ff     <= 1'b0;
         stat_ff      <= tsss_pkg::STAT_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         elapsed_ff   <= elapsed_in;
         real_on_ff   <= real_on_in;
         triac_ff     <= triac_in;
         relay_ff     <= relay_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) begin
         out_on_ff <= real_on_ff;
      end
   end

   assign status.in_phase = in_phase;
   assign status.div_done = div_done;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_triac_drive    = triac_ff;
   assign rsp_relay_drive    = relay_ff;
   assign rsp_channel_status = stat_ff;
   assign rsp_output_is_on   = out_on_ff;

endmodule

`default_nettype wire

@@ src/tsss_controller.sv @@
`default_nettype none

module tsss_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tsss_pkg::status_type   status,
   output tsss_pkg::cmd_type           cmd
);

   tsss_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsss_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               state_in = tsss_pkg::CTRL_START;
            end
         end
         tsss_pkg::CTRL_START: begin
            state_in = status.in_phase ? tsss_pkg::CTRL_DIVIDE : tsss_pkg::CTRL_FINISH;
         end
         tsss_pkg::CTRL_DIVIDE: begin
            if (status.div_done) begin
               state_in = tsss_pkg::CTRL_FINISH;
            end
         end
         tsss_pkg::CTRL_FINISH: begin
            if (status.out_free) begin
               state_in = tsss_pkg::CTRL_IDLE;
            end
         end
         default: state_in = tsss_pkg::CTRL_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.transition = 1'b0;
      cmd.div_start  = 1'b0;
      cmd.finish     = 1'b0;
      case (state_ff)
         tsss_pkg::CTRL_IDLE: begin
            req_ready      = 1'b1;
            cmd.transition = req_valid;
         end
         tsss_pkg::CTRL_START: begin
            cmd.div_start = status.in_phase;
         end
         tsss_pkg::CTRL_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsss_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/triac_relay_soft_start_sequencer.sv @@
`default_nettype none

// Soft-start sequencer for one triac/relay channel. Each transfer on the req_
// channel is one control tick carrying the wanted on/off state; each tick
// gives exactly one transfer on the rsp_ channel with the triac and relay
// drives, the channel status (off, on, soft starting, cooling) and the real
// output state. Turning on walks through four soft-start phases in which the
// triac pulses while the elapsed time modulo the phase period is below the
// pulse width; then the relay takes over and a cooling wait follows. The state
// transition is done at the acceptance edge itself. A tick in a soft-start
// phase then goes through launching the remainder unit, the bit-serial
// remainder of the 16-bit time, the hand-over to the decode, and the decode
// that registers the result; any other tick goes through picking the decode
// path and then the decode and register step. A result still waiting in the
// output register holds the next one in its decode step. The next tick is
// accepted once the controller is back in idle after the result is loaded.
// Registers are written through the csr_ port, which is always ready; the
// user must write them only while no tick is in flight (not enforced here).
module triac_relay_soft_start_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tick input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_wanted_on,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_triac_drive,
   output logic                                   rsp_relay_drive,
   output logic [1:0]                             rsp_channel_status,
   output logic                                   rsp_output_is_on,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tsss_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [tsss_pkg::CFG_W-1:0]        csr_data
);

   // command and status between control and datapath
   tsss_pkg::cmd_type    cmd;
   tsss_pkg::status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencing of transition, remainder and decode
   tsss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, sequencer state, remainder unit and output register
   tsss_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_wanted_on      (req_wanted_on),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_triac_drive    (rsp_triac_drive),
      .rsp_relay_drive    (rsp_relay_drive),
      .rsp_channel_status (rsp_channel_status),
      .rsp_output_is_on   (rsp_output_is_on)
   );

endmodule

`default_nettype wire
